// ----- design/uuidp_pkg.sv -----
// ----------------------------------------------------------------------------
// uuidp_pkg
// Types, codes and character helpers for the UUID text parser.
// ----------------------------------------------------------------------------
package uuidp_pkg;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_PAIR  = 2'd1,
    PH_LOW   = 2'd2,
    PH_TRAIL = 2'd3
  } phase_t;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_BYTE = 2'd0;
  localparam kind_t KIND_OK   = 2'd1;
  localparam kind_t KIND_ERR  = 2'd2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;

  // Space, tab, LF, VT, FF and CR.
  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage

// ----- design/uuid_text_parser.sv -----
// ----------------------------------------------------------------------------
// uuid_text_parser
// Parses a UUID string, one character per transfer, into bytes and a status.
// ----------------------------------------------------------------------------
//
//   channel | signals                                      | role
//   --------+----------------------------------------------+----------------
//   in      | in_valid, in_ready, char_code[7:0]           | characters
//   out     | out_valid, out_ready, result_kind[1:0],      | bytes / status
//           | byte_value[7:0], byte_index[3:0]             |
//
// One character is taken per cycle while the output is not stalled; the state
// update and the result decode are one level of logic in front of a single result register.
// A character is taken whenever the result register is empty or being
// drained, so a stall on the output holds off only the next character.
// Reset (rst, synchronous) returns the parser to the leading-whitespace
// phase and empties the result register.
// The result of a character is visible the cycle after its transfer.
// ----------------------------------------------------------------------------
module uuid_text_parser #(
  parameter int UUID_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] result_kind,
  output logic [7:0] byte_value,
  output logic [3:0] byte_index
);
  import uuidp_pkg::*;

  localparam int CntW = $clog2(UUID_BYTES + 1);
  localparam logic [CntW-1:0] LastByte = CntW'(UUID_BYTES - 1);

  phase_t          phase, phase_next;
  logic [CntW-1:0] bytes_done, bytes_done_next;
  logic [3:0]      high_digit, high_digit_next;
  logic            error_seen, error_seen_next;

  logic            in_accept;
  logic            res_valid;
  kind_t           res_kind;
  logic [7:0]      res_value;
  logic [3:0]      res_index;

  logic            c_nul, c_space, c_sep, c_bad;
  logic [4:0]      c_hex;
  logic [CntW+3:0] cnt_ext;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign c_nul   = (char_code == CHAR_NUL);
  assign c_space = is_space(char_code);
  assign c_sep   = (char_code == CHAR_DASH) || (char_code == CHAR_SPACE);
  assign c_hex   = hex_value(char_code);
  assign c_bad   = c_hex[4];
  assign cnt_ext = {4'd0, bytes_done};

  // Next parser state.
  always_comb begin
    phase_next      = phase;
    bytes_done_next = bytes_done;
    high_digit_next = high_digit;
    error_seen_next = error_seen;
    priority if (c_nul) begin
      phase_next      = PH_LEAD;
      bytes_done_next = '0;
      high_digit_next = '0;
      error_seen_next = 1'b0;
    end else if (error_seen) begin
      // Everything up to the terminator is dropped.
    end else if (phase == PH_TRAIL) begin
      if (!c_space) begin
        error_seen_next = 1'b1;
      end
    end else if (phase == PH_LOW) begin
      if (c_bad) begin
        error_seen_next = 1'b1;
      end else begin
        high_digit_next = '0;
        if (bytes_done == LastByte) begin
          phase_next      = PH_TRAIL;
          bytes_done_next = '0;
        end else begin
          phase_next      = PH_PAIR;
          bytes_done_next = bytes_done + 1'b1;
        end
      end
    end else if (phase == PH_LEAD && c_space) begin
      // Leading whitespace is skipped.
    end else begin
      // First digit of a pair or a separator before it, possibly the first non-space character.
      phase_next = PH_PAIR;
      if (c_sep) begin
      end else if (c_bad) begin
        error_seen_next = 1'b1;
      end else begin
        high_digit_next = c_hex[3:0];
        phase_next      = PH_LOW;
      end
    end
  end

  // Result of the current character.
  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_BYTE;
    res_value = '0;
    res_index = '0;
    if (c_nul) begin
      res_valid = 1'b1;
      res_kind  = (!error_seen && phase == PH_TRAIL) ? KIND_OK : KIND_ERR;
    end else if (!error_seen && phase == PH_LOW && !c_bad) begin
      res_valid = 1'b1;
      res_value = {high_digit, c_hex[3:0]};
      res_index = cnt_ext[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEAD;
      bytes_done <= '0;
      high_digit <= '0;
      error_seen <= 1'b0;
    end else if (in_accept) begin
      phase      <= phase_next;
      bytes_done <= bytes_done_next;
      high_digit <= high_digit_next;
      error_seen <= error_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      result_kind <= res_kind;
      byte_value  <= res_value;
      byte_index  <= res_index;
    end
  end

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && c_nul |=> phase == PH_LEAD && bytes_done == '0 && !error_seen)
    else $error("terminator did not return the parser to idle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bytes_done <= LastByte)
    else $error("byte count beyond the UUID length");

  a_trail_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TRAIL |-> bytes_done == '0)
    else $error("byte count not cleared after the last pair");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_BYTE |->
      byte_value == '0 && byte_index == '0 &&
      (result_kind == KIND_OK || result_kind == KIND_ERR))
    else $error("malformed status result");

  a_ok_after_trail: assert property (@(posedge clk) disable iff (rst)
    in_accept && c_nul && phase != PH_TRAIL |=> out_valid && result_kind == KIND_ERR)
    else $error("early terminator not reported as an error");

endmodule
